// File: design/terminal_line_editor_core_defines.svh
// ----------------------------------------------------------------------------
// Terminal line editor assertion macros
// Shared check macros; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TERMINAL_LINE_EDITOR_CORE_DEFINES_SVH
`define TERMINAL_LINE_EDITOR_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, checked on every rising edge out of reset
`define TLE_ASSERT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
// next-cycle implication
`define TLE_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define TLE_ASSERT(label, cond, prop)
`define TLE_ASSERT_NEXT(label, cond, prop)
`endif

`endif

// File: design/tle_pkg.sv
// ----------------------------------------------------------------------------
// Terminal line editor package
// Character codes, event codes and the result descriptor type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tle_pkg;

  localparam logic [7:0] CH_BS     = 8'd8;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_ESC    = 8'd27;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_UPKEY  = 8'h41;
  localparam logic [7:0] CH_DNKEY  = 8'h42;
  localparam logic [7:0] CH_DEL    = 8'd127;

  localparam logic [1:0] EVT_NONE = 2'd0;
  localparam logic [1:0] EVT_DONE = 2'd1;
  localparam logic [1:0] EVT_UP   = 2'd2;
  localparam logic [1:0] EVT_DOWN = 2'd3;

  localparam logic [8:0] MAX_LEN_RESET = 9'd64;

  typedef enum logic [2:0] {
    KIND_CHAR,
    KIND_BS,
    KIND_CR,
    KIND_UP,
    KIND_DOWN
  } kind_t;

  // one decoded input byte: what to emit and with which data
  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic [8:0] len;
  } desc_t;

endpackage

// File: design/tle_decode.sv
// ----------------------------------------------------------------------------
// Terminal line editor decoder
// Holds escape mode and line length; classifies each byte into a descriptor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tle_decode #(
  parameter int LINE_CAPACITY = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  logic [7:0]      ch,
  input  logic [8:0]      max_line_len,
  output logic            has_result,
  output tle_pkg::desc_t  desc
);

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_ESC,
    MODE_BRACKET
  } mode_t;

  mode_t      escape_mode, escape_mode_next;
  logic [8:0] line_count, line_count_next;
  logic       room;

  assign room = (line_count < max_line_len) &&
                (32'(line_count) < LINE_CAPACITY) &&
                (line_count != 9'h1FF);

  always_comb begin
    escape_mode_next = MODE_NORMAL;
    line_count_next  = line_count;
    has_result       = 1'b0;
    desc.kind        = tle_pkg::KIND_CHAR;
    desc.ch          = ch;
    desc.len         = line_count;
    case (escape_mode)
      MODE_ESC: begin
        if (ch == tle_pkg::CH_LBRACK) begin
          escape_mode_next = MODE_BRACKET;
        end
      end
      MODE_BRACKET: begin
        if (ch == tle_pkg::CH_UPKEY) begin
          has_result = 1'b1;
          desc.kind  = tle_pkg::KIND_UP;
        end else if (ch == tle_pkg::CH_DNKEY) begin
          has_result = 1'b1;
          desc.kind  = tle_pkg::KIND_DOWN;
        end
      end
      default: begin
        if (ch == tle_pkg::CH_ESC) begin
          escape_mode_next = MODE_ESC;
        end else if (ch == tle_pkg::CH_BS || ch == tle_pkg::CH_DEL) begin
          if (line_count != 9'd0) begin
            has_result      = 1'b1;
            desc.kind       = tle_pkg::KIND_BS;
            line_count_next = line_count - 9'd1;
          end
        end else if (ch == tle_pkg::CH_CR) begin
          has_result      = 1'b1;
          desc.kind       = tle_pkg::KIND_CR;
          line_count_next = 9'd0;
        end else if (ch >= tle_pkg::CH_SPACE && ch < tle_pkg::CH_DEL && room) begin
          has_result      = 1'b1;
          desc.kind       = tle_pkg::KIND_CHAR;
          line_count_next = line_count + 9'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_mode <= MODE_NORMAL;
      line_count  <= 9'd0;
    end else if (fire) begin
      escape_mode <= escape_mode_next;
      line_count  <= line_count_next;
    end
  end

endmodule

// File: design/tle_emit.sv
// ----------------------------------------------------------------------------
// Terminal line editor result emitter
// Result register; steps a backspace through its three echo bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tle_emit (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  tle_pkg::desc_t  load_desc,
  output logic            can_load,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            echo_valid,
  output logic [7:0]      echo_byte,
  output logic            store_valid,
  output logic [7:0]      store_index,
  output logic [7:0]      store_char,
  output logic [1:0]      event_res,
  output logic [8:0]      line_length,
  output logic            last
);

  logic           busy;
  tle_pkg::desc_t desc;
  logic [1:0]     step;

  assign out_valid = busy;
  assign can_load  = !busy || (out_ready && last);

  always_comb begin
    echo_valid  = 1'b0;
    echo_byte   = 8'd0;
    store_valid = 1'b0;
    store_index = 8'd0;
    store_char  = 8'd0;
    event_res   = tle_pkg::EVT_NONE;
    line_length = 9'd0;
    last        = 1'b1;
    case (desc.kind)
      tle_pkg::KIND_CHAR: begin
        echo_valid  = 1'b1;
        echo_byte   = desc.ch;
        store_valid = 1'b1;
        store_index = desc.len[7:0];
        store_char  = desc.ch;
      end
      tle_pkg::KIND_BS: begin
        // backspace, space, backspace
        echo_valid = 1'b1;
        echo_byte  = (step == 2'd1) ? tle_pkg::CH_SPACE : tle_pkg::CH_BS;
        last       = (step == 2'd2);
      end
      tle_pkg::KIND_CR: begin
        echo_valid  = 1'b1;
        echo_byte   = tle_pkg::CH_LF;
        event_res   = tle_pkg::EVT_DONE;
        line_length = desc.len;
      end
      tle_pkg::KIND_UP: begin
        event_res   = tle_pkg::EVT_UP;
        line_length = desc.len;
      end
      tle_pkg::KIND_DOWN: begin
        event_res   = tle_pkg::EVT_DOWN;
        line_length = desc.len;
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
    end else if (load) begin
      busy <= 1'b1;
      step <= 2'd0;
    end else if (busy && out_ready) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        step <= step + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      desc <= load_desc;
    end
  end

endmodule

// File: design/terminal_line_editor_core.sv
// ----------------------------------------------------------------------------
// Terminal line editor core
// Echo, line buffer writes and line/arrow events from received terminal bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on rx_byte with in_valid/in_ready. Results leave on
//   out_valid/out_ready, one result per transfer; last marks the final
//   result of a byte. Printable bytes while the line has room, carriage
//   return and arrow keys give one result, a backspace on a non-empty line
//   gives three, all other bytes give none.
//   A byte is decoded from the input register into the result register.
//   Throughput: one byte per cycle while out_ready stays high, except that
//   a backspace holds the result register while its three echo bytes drain.
//   The input register takes a new byte while a result waits, so one byte
//   is held ahead of a stalled receiver; when out_ready stays low both
//   registers fill and in_ready drops.
//   max_line_len is written through cfg_write_en/cfg_write_data; the user
//   must do so only while idle, as the block does not enforce this.
//   Reset (rst, synchronous) empties both registers, sets normal mode, an
//   empty line and max_line_len of 64.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "terminal_line_editor_core_defines.svh"

module terminal_line_editor_core #(
  parameter int LINE_CAPACITY = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic [8:0] cfg_write_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       echo_valid,
  output logic [7:0] echo_byte,
  output logic       store_valid,
  output logic [7:0] store_index,
  output logic [7:0] store_char,
  output logic [1:0] event_res,
  output logic [8:0] line_length,
  output logic       last
);

  logic [8:0]     max_line_len;
  logic           hold_valid;
  logic [7:0]     hold_byte;
  logic           can_load;
  logic           fire;
  logic           has_result;
  tle_pkg::desc_t desc;

  assign fire     = hold_valid && can_load;
  assign in_ready = !hold_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_len <= tle_pkg::MAX_LEN_RESET;
    end else if (cfg_write_en) begin
      max_line_len <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= rx_byte;
    end
  end

  tle_decode #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_decode (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .ch           (hold_byte),
    .max_line_len (max_line_len),
    .has_result   (has_result),
    .desc         (desc)
  );

  tle_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (fire && has_result),
    .load_desc   (desc),
    .can_load    (can_load),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .echo_valid  (echo_valid),
    .echo_byte   (echo_byte),
    .store_valid (store_valid),
    .store_index (store_index),
    .store_char  (store_char),
    .event_res   (event_res),
    .line_length (line_length),
    .last        (last)
  );

  `TLE_ASSERT(a_store_echoes, out_valid && store_valid, echo_valid && echo_byte == store_char)
  `TLE_ASSERT(a_event_is_last, out_valid && event_res != tle_pkg::EVT_NONE, last)
  `TLE_ASSERT(a_mid_is_erase, out_valid && !last,
              echo_byte == tle_pkg::CH_BS || echo_byte == tle_pkg::CH_SPACE)
  `TLE_ASSERT_NEXT(a_erase_holds, out_valid && out_ready && !last, out_valid)

endmodule
